// ===== rtl/core/threshold_run_pixel_sorter_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the threshold run pixel sorter
// Shared concurrent assertion forms, sampled on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_RUN_PIXEL_SORTER_CORE_DEFINES_SVH
`define THRESHOLD_RUN_PIXEL_SORTER_CORE_DEFINES_SVH

// Condition in one cycle implies a consequence in the same cycle.
`define TRS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("threshold_run_pixel_sorter_core: same-cycle check failed");

// Condition in one cycle implies a consequence in the next cycle.
`define TRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("threshold_run_pixel_sorter_core: next-cycle check failed");

`endif

// ===== rtl/core/trs_pkg.sv =====
// ----------------------------------------------------------------------------
// trs_pkg
// Types and constants shared by the threshold run pixel sorter modules.
// ----------------------------------------------------------------------------
package trs_pkg;

    localparam int PIXEL_W  = 32;
    localparam int THRESH_W = 8;
    localparam int SUM_W    = 10;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd128;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_EMIT,
        ST_LOAD
    } state_t;

    // Command broadcast to every cell of the sorting chain.
    typedef struct packed {
        logic               insert;
        logic               shift;
        logic [PIXEL_W-1:0] data;
    } chain_ctl_t;

endpackage

// ===== rtl/core/trs_cell.sv =====
// ----------------------------------------------------------------------------
// trs_cell
// One slot of the sorted insertion chain: holds one pixel and a valid bit.
// ----------------------------------------------------------------------------
module trs_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  trs_pkg::chain_ctl_t           ctl,
    input  logic                          left_lt,
    input  logic [trs_pkg::PIXEL_W-1:0]   left_val,
    input  logic                          left_vld,
    input  logic [trs_pkg::PIXEL_W-1:0]   right_val,
    input  logic                          right_vld,
    output logic [trs_pkg::PIXEL_W-1:0]   val,
    output logic                          vld,
    output logic                          lt
);
    import trs_pkg::*;

    logic [PIXEL_W-1:0] val_reg;
    logic [PIXEL_W-1:0] val_next;
    logic               vld_reg;
    logic               vld_next;

    // The new pixel belongs at or left of this slot when it is smaller than
    // the held pixel; an empty slot counts as larger than anything.
    assign lt = !vld_reg || (ctl.data < val_reg);

    // Insert takes the left neighbor when the new pixel lands further left;
    // shift moves the whole chain one slot toward the head.
    always_comb
    begin
        val_next = val_reg;
        vld_next = vld_reg;
        if (ctl.insert && lt)
        begin
            if (left_lt)
            begin
                val_next = left_val;
                vld_next = left_vld;
            end
            else
            begin
                val_next = ctl.data;
                vld_next = 1'b1;
            end
        end
        else if (ctl.shift)
        begin
            val_next = right_val;
            vld_next = right_vld;
        end
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Pixel payload.
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
    assign vld = vld_reg;

endmodule

// ===== rtl/core/threshold_run_pixel_sorter_core.sv =====
// ----------------------------------------------------------------------------
// threshold_run_pixel_sorter_core
// Sorts runs of bright pixels within a row by raw value using a chain of
// insertion cells; dark pixels pass through in order.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  input    in         in_valid/in_stall   pixel_in, last_in_row
//  output   out        out_valid/out_stall pixel_out, row_end, last_of_batch
//  config   in         cfg_valid/cfg_ready threshold
//
// A request that only opens or extends a run is inserted as it is accepted.
// A request that releases results is accepted first; its results then leave
// the chain head and the breaking pixel is loaded afterwards if it opens a new
// run. The output port moves one pixel per cycle when out_stall is low.
// Reset empties the chain and sets the threshold to 128; no clearing pass.
// A stalled result holds the chain and sequencer until it is taken.
// ----------------------------------------------------------------------------
module threshold_run_pixel_sorter_core #(
    parameter int ROW_WIDTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [trs_pkg::PIXEL_W-1:0]    pixel_in,
    input  logic                           last_in_row,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [trs_pkg::PIXEL_W-1:0]    pixel_out,
    output logic                           row_end,
    output logic                           last_of_batch,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [trs_pkg::THRESH_W-1:0]   threshold
);
    import trs_pkg::*;

    localparam int CNT_W = $clog2(ROW_WIDTH + 1);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [THRESH_W-1:0] thresh_reg;
    logic [PIXEL_W-1:0] pend_px_reg;
    logic [PIXEL_W-1:0] pend_px_next;
    logic               last_reg;
    logic               last_next;
    logic               fresh_reg;
    logic               fresh_next;
    logic               emit_px_reg;
    logic               emit_px_next;

    logic               in_acc;
    logic               out_acc;
    logic [SUM_W-1:0]   sum;
    logic [SUM_W-1:0]   thr3;
    logic               ge;
    logic               gt;
    logic               have_run;
    logic               join_run;
    logic               opens;
    logic               run_full;
    logic               drain_done;
    chain_ctl_t         ctl;

    logic [PIXEL_W-1:0] cv  [ROW_WIDTH+1];
    logic               cvl [ROW_WIDTH+1];
    logic               clt [ROW_WIDTH];

    // Handshakes.
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;
    assign cfg_ready = 1'b1;

    // Intensity tests without a divider: floor(s/3) >= t iff s >= 3t,
    // and floor(s/3) > t iff s >= 3t + 3.
    assign sum  = SUM_W'(pixel_in[7:0]) + SUM_W'(pixel_in[15:8])
                + SUM_W'(pixel_in[23:16]);
    assign thr3 = SUM_W'({thresh_reg, 1'b0}) + SUM_W'(thresh_reg);
    assign ge   = (sum >= thr3);
    assign gt   = (sum >= (thr3 + SUM_W'(3)));

    assign have_run   = (count_reg != '0);
    assign join_run   = have_run && gt;
    assign opens      = ge && !last_in_row;
    assign run_full   = (count_reg == CNT_W'(ROW_WIDTH - 1));
    assign drain_done = out_acc && (count_reg == CNT_W'(1));

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (join_run)
                    begin
                        state_next = (last_in_row || run_full) ? ST_DRAIN : ST_IDLE;
                    end
                    else if (have_run)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        state_next = opens ? ST_IDLE : ST_EMIT;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (drain_done)
                begin
                    if (emit_px_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (fresh_reg)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Chain commands, run count and held request.
    always_comb
    begin
        ctl.insert   = 1'b0;
        ctl.shift    = 1'b0;
        ctl.data     = pixel_in;
        count_next   = count_reg;
        pend_px_next = pend_px_reg;
        last_next    = last_reg;
        fresh_next   = fresh_reg;
        emit_px_next = emit_px_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    pend_px_next = pixel_in;
                    last_next    = last_in_row;
                    fresh_next   = have_run && !gt && opens;
                    emit_px_next = have_run && !gt && !opens;
                    if (join_run || (!have_run && opens))
                    begin
                        ctl.insert = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_acc)
                begin
                    ctl.shift  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_LOAD:
            begin
                ctl.insert = 1'b1;
                ctl.data   = pend_px_reg;
                count_next = CNT_W'(1);
            end
            ST_EMIT:
            begin
                count_next = count_reg;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Output selection: sorted run from the chain head, then the held pixel.
    always_comb
    begin
        out_valid     = 1'b0;
        pixel_out     = pend_px_reg;
        last_of_batch = 1'b0;
        case (state_reg)
            ST_DRAIN:
            begin
                out_valid     = 1'b1;
                pixel_out     = cv[0];
                last_of_batch = (count_reg == CNT_W'(1)) && !emit_px_reg;
            end
            ST_EMIT:
            begin
                out_valid     = 1'b1;
                last_of_batch = 1'b1;
            end
            default:
            begin
                out_valid = 1'b0;
            end
        endcase
        row_end = last_of_batch && last_reg;
    end

    // Control state and threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            thresh_reg  <= THRESH_RESET;
            fresh_reg   <= 1'b0;
            emit_px_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            fresh_reg   <= fresh_next;
            emit_px_reg <= emit_px_next;
            if (cfg_valid && cfg_ready)
            begin
                thresh_reg <= threshold;
            end
        end
    end

    // Held request payload.
    always_ff @(posedge clk)
    begin
        pend_px_reg <= pend_px_next;
        last_reg    <= last_next;
    end

    // Right end of the chain reads as empty.
    assign cv[ROW_WIDTH]  = '0;
    assign cvl[ROW_WIDTH] = 1'b0;

    // Row of insertion cells, head at index 0.
    for (genvar i = 0; i < ROW_WIDTH; i++)
    begin : g_cell
        logic               l_lt;
        logic [PIXEL_W-1:0] l_val;
        logic               l_vld;

        if (i == 0)
        begin : g_head
            assign l_lt  = 1'b0;
            assign l_val = '0;
            assign l_vld = 1'b0;
        end
        else
        begin : g_body
            assign l_lt  = clt[i-1];
            assign l_val = cv[i-1];
            assign l_vld = cvl[i-1];
        end

        trs_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .left_lt   (l_lt),
            .left_val  (l_val),
            .left_vld  (l_vld),
            .right_val (cv[i+1]),
            .right_vld (cvl[i+1]),
            .val       (cv[i]),
            .vld       (cvl[i]),
            .lt        (clt[i])
        );
    end

endmodule

// ===== rtl/core/trs_checker.sv =====
// ----------------------------------------------------------------------------
// trs_checker
// Port-level checks for the threshold run pixel sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "threshold_run_pixel_sorter_core_defines.svh"

module trs_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [trs_pkg::PIXEL_W-1:0]  pixel_out,
    input  logic                         row_end,
    input  logic                         last_of_batch
);
    import trs_pkg::*;

    // A stalled result keeps its pixel.
    `TRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pixel_out))

    // Row end only ever marks the final result of a request.
    `TRS_ASSERT_NOW(a_row_end_last, out_valid && row_end, last_of_batch)

    // No request is taken while results are still being shown.
    `TRS_ASSERT_NOW(a_no_overlap, in_valid && !in_stall, !out_valid)

    // After the final result of a request is taken, the output goes quiet.
    `TRS_ASSERT_NEXT(a_batch_end, out_valid && !out_stall && last_of_batch, !out_valid)

endmodule

bind threshold_run_pixel_sorter_core trs_checker u_trs_checker (.*);
